@@ hdl/sfb_pkg.sv @@
// sfb_pkg: shared types, constants and checksum helper for the stuffed frame builder.
// No dependencies; every other file refers to it by scoped names.
package sfb_pkg;

	localparam int BYTE_W    = 8;
	localparam int SUM_W     = 16;
	localparam int MAX_OUT   = 7;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLAG   = 2'd0,
		CFG_ESCAPE = 2'd1
	} sfb_cfg_idx_t;

	// Current configuration register values
	typedef struct packed {
		logic [BYTE_W-1:0] flag;
		logic [BYTE_W-1:0] escape;
	} sfb_cfg_t;

	// All result bytes caused by one input item
	typedef struct packed {
		logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]               count;
	} sfb_result_t;

	// Checksum pairing state
	typedef struct packed {
		logic              odd;
		logic [BYTE_W-1:0] pend;
		logic [SUM_W-1:0]  sum;
	} sfb_sum_t;

	// Account one stuffed byte: hold it as the high half or fold in a full word
	function automatic sfb_sum_t sum_byte(input sfb_sum_t st, input logic [BYTE_W-1:0] b);
		sfb_sum_t         r;
		logic [SUM_W:0]   s;
		r = st;
		s = {1'b0, st.sum} + {1'b0, st.pend, b};
		if (st.odd) begin
			r.sum  = s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
			r.odd  = 1'b0;
			r.pend = '0;
		end else begin
			r.pend = b;
			r.odd  = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ hdl/stuffed_frame_builder_with_checksum_top.sv @@
// stuffed_frame_builder_with_checksum_top: framing, byte stuffing and 16-bit checksum.
// Depends on sfb_pkg, sfb_cfg_regs, sfb_encoder and sfb_out_buffer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid / in_stall    | data_byte, last_byte
//  out     | output    | out_valid / out_stall  | out_byte, out_last
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item waits in the input register until the result register takes it; its 1 to 6
// result bytes then leave one per cycle while out_stall is low, and the next item loads as
// the final byte leaves, so the output moves a byte every cycle while items keep coming
// and out_stall stays low. An item passes the input and result registers before it shows.
// Reset clears the frame state and both valid flags; configuration returns to flag 0x7E,
// escape 0x7D. A stalled output holds its byte and backs up into in_stall after one item.
module stuffed_frame_builder_with_checksum_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sfb_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sfb_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfb_pkg::BYTE_W-1:0]      cfg_data
);

	sfb_pkg::sfb_cfg_t    cfg;
	sfb_pkg::sfb_result_t res;
	logic                 res_valid;
	logic                 res_take;

	sfb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfb_encoder u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	sfb_out_buffer u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

@@ hdl/sfb_cfg_regs.sv @@
// sfb_cfg_regs: flag and escape configuration registers with their write port.
// Depends on sfb_pkg.
module sfb_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sfb_pkg::BYTE_W-1:0]         cfg_data,
	output sfb_pkg::sfb_cfg_t                  cfg
);

	logic [sfb_pkg::BYTE_W-1:0] flag_q;
	logic [sfb_pkg::BYTE_W-1:0] escape_q;

	// Always take writes
	assign cfg_ready = 1'b1;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= sfb_pkg::FLAG_RESET;
			escape_q <= sfb_pkg::ESCAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfb_pkg::CFG_FLAG:   flag_q   <= cfg_data;
				sfb_pkg::CFG_ESCAPE: escape_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.flag   = flag_q;
	assign cfg.escape = escape_q;

endmodule

@@ hdl/sfb_encoder.sv @@
// sfb_encoder: input register, frame state and the single-pass stuffing/checksum logic.
// Depends on sfb_pkg; feeds sfb_out_buffer with one result group per item.
module sfb_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sfb_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        last_byte,
	input  sfb_pkg::sfb_cfg_t           cfg,
	output logic                        res_valid,
	output sfb_pkg::sfb_result_t        res,
	input  logic                        res_take
);

	logic                       valid_s1;
	logic [sfb_pkg::BYTE_W-1:0] data_s1;
	logic                       last_s1;

	logic                       in_frame_q;
	sfb_pkg::sfb_sum_t          sum_q;

	logic                       in_frame_d;
	sfb_pkg::sfb_sum_t          sum_d;

	// Stall while the held item cannot move to the result stage
	assign in_stall  = valid_s1 && !res_take;
	assign res_valid = valid_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (res_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Build the result bytes and the next frame state for the held item
	always_comb begin
		sfb_pkg::sfb_sum_t          st;
		logic [sfb_pkg::CNT_W-1:0]  n;
		logic                       esc;
		logic [sfb_pkg::SUM_W-1:0]  ck;
		st        = in_frame_q ? sum_q : '0;
		n         = '0;
		ck        = '0;
		res.bytes = '0;
		esc       = (data_s1 == cfg.flag) || (data_s1 == cfg.escape);
		if (!in_frame_q) begin
			res.bytes[n] = cfg.flag;
			n            = n + 1'b1;
		end
		if (esc) begin
			res.bytes[n] = cfg.escape;
			n            = n + 1'b1;
			st           = sfb_pkg::sum_byte(st, cfg.escape);
		end
		res.bytes[n] = data_s1;
		n            = n + 1'b1;
		st           = sfb_pkg::sum_byte(st, data_s1);
		in_frame_d   = 1'b1;
		sum_d        = st;
		if (last_s1) begin
			// pad an odd length, then checksum and closing flag
			if (st.odd) begin
				res.bytes[n] = '0;
				n            = n + 1'b1;
				st           = sfb_pkg::sum_byte(st, '0);
			end
			ck           = ~st.sum;
			res.bytes[n] = ck[sfb_pkg::SUM_W-1 -: sfb_pkg::BYTE_W];
			n            = n + 1'b1;
			res.bytes[n] = ck[sfb_pkg::BYTE_W-1:0];
			n            = n + 1'b1;
			res.bytes[n] = cfg.flag;
			n            = n + 1'b1;
			in_frame_d   = 1'b0;
			sum_d        = '0;
		end
		res.count = n;
	end

	// Advance frame state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			sum_q      <= '0;
		end else if (res_take) begin
			in_frame_q <= in_frame_d;
			sum_q      <= sum_d;
		end
	end

endmodule

@@ hdl/sfb_out_buffer.sv @@
// sfb_out_buffer: result register holding one item's bytes and the serializer that sends them.
// Depends on sfb_pkg; loads from sfb_encoder.
module sfb_out_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	input  sfb_pkg::sfb_result_t        res,
	output logic                        res_take,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sfb_pkg::BYTE_W-1:0]  out_byte,
	output logic                        out_last
);

	logic                                       valid_s2;
	logic [sfb_pkg::MAX_OUT-1:0][sfb_pkg::BYTE_W-1:0] bytes_s2;
	logic [sfb_pkg::CNT_W-1:0]                  count_s2;
	logic [sfb_pkg::CNT_W-1:0]                  idx_q;
	logic                                       send;

	assign out_valid = valid_s2;
	assign out_byte  = bytes_s2[idx_q];
	assign out_last  = (idx_q == count_s2 - 1'b1);
	assign send      = valid_s2 && !out_stall;

	// Load the next group when empty or while the final byte leaves
	assign res_take  = res_valid && (!valid_s2 || (send && out_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (res_take) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (send) begin
			if (out_last) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			bytes_s2 <= res.bytes;
			count_s2 <= res.count;
		end
	end

endmodule

@@ hdl/sfb_checker.sv @@
// sfb_checker: port-level assertions for the stuffed frame builder, bound to the top level.
// Depends on sfb_pkg and stuffed_frame_builder_with_checksum_top.
module sfb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [sfb_pkg::BYTE_W-1:0]      out_byte,
	input  logic                            out_last,
	input  logic                            cfg_ready
);

	// Hold a stalled result byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled result item changed");

	// Never stall the input while the output side is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// Continue a result group until its last byte
	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_last |=> out_valid)
		else $error("result group cut short");

	// An accepted item shows a valid output once it has passed the input and result registers
	a_accept_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted item produced no result");

	// Configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind stuffed_frame_builder_with_checksum_top sfb_checker u_sfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.out_last  (out_last),
	.cfg_ready (cfg_ready)
);

@@ bench/sfb_line_model_pkg.sv @@
`timescale 1ns / 100ps
// sfb_line_model_pkg: line byte predictor and checker for the stuffed frame builder bench.
// Depends on sfb_pkg for widths, reset values and register indexes.
package sfb_line_model_pkg;

	localparam logic [sfb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [sfb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam logic [sfb_pkg::BYTE_W-1:0]    PAD_BYTE    = 8'h00;

	class stuffed_stream_tracker;
		typedef struct packed {
			logic [sfb_pkg::BYTE_W-1:0] value;
			logic                       tail;
		} line_byte_t;

		logic [sfb_pkg::BYTE_W-1:0] flag;
		logic [sfb_pkg::BYTE_W-1:0] escape;
		bit                         open_frame;
		bit                         half_word;
		logic [sfb_pkg::BYTE_W-1:0] held_high;
		logic [sfb_pkg::SUM_W-1:0]  csum;
		line_byte_t                 expected_line_bytes[$];
		int errors;
		int inputs_seen;
		int bytes_checked;
		int frames_closed;
		int escapes_seen;
		int pads_seen;

		function new();
			flag          = sfb_pkg::FLAG_RESET;
			escape        = sfb_pkg::ESCAPE_RESET;
			open_frame    = 1'b0;
			half_word     = 1'b0;
			held_high     = '0;
			csum          = '0;
			errors        = 0;
			inputs_seen   = 0;
			bytes_checked = 0;
			frames_closed = 0;
			escapes_seen  = 0;
			pads_seen     = 0;
		endfunction

		// Apply one register write; unused indexes drop
		function void set_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx,
				input logic [sfb_pkg::BYTE_W-1:0] value);
			case (idx)
				sfb_pkg::CFG_FLAG: begin
					flag = value;
				end
				sfb_pkg::CFG_ESCAPE: begin
					escape = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Pair stuffed bytes high first and fold each word with end-around carry
		function void add_to_sum(input logic [sfb_pkg::BYTE_W-1:0] b);
			logic [sfb_pkg::SUM_W:0] wide;
			if (half_word) begin
				wide      = {1'b0, csum} + {1'b0, held_high, b};
				csum      = wide[sfb_pkg::SUM_W-1:0] + wide[sfb_pkg::SUM_W];
				half_word = 1'b0;
				held_high = '0;
			end else begin
				held_high = b;
				half_word = 1'b1;
			end
		endfunction

		// Work out the line bytes one accepted message byte causes
		function void predict_frame_bytes(input logic [sfb_pkg::BYTE_W-1:0] value,
				input logic tail);
			logic [sfb_pkg::BYTE_W-1:0] seq[$];
			logic [sfb_pkg::SUM_W-1:0]  folded;
			line_byte_t                 entry;
			inputs_seen++;
			// open a frame with the flag, which stays out of the sum
			if (!open_frame) begin
				open_frame = 1'b1;
				half_word  = 1'b0;
				held_high  = '0;
				csum       = '0;
				seq.push_back(flag);
			end
			// escape data that looks like a flag or an escape; the byte itself goes as is
			if (value == flag || value == escape) begin
				seq.push_back(escape);
				add_to_sum(escape);
				escapes_seen++;
			end
			seq.push_back(value);
			add_to_sum(value);
			// close: pad an odd length, then complemented sum and closing flag
			if (tail) begin
				if (half_word) begin
					seq.push_back(PAD_BYTE);
					add_to_sum(PAD_BYTE);
					pads_seen++;
				end
				folded = ~csum;
				seq.push_back(folded[15:8]);
				seq.push_back(folded[7:0]);
				seq.push_back(flag);
				open_frame = 1'b0;
				half_word  = 1'b0;
				held_high  = '0;
				csum       = '0;
				frames_closed++;
			end
			foreach (seq[i]) begin
				entry.value = seq[i];
				entry.tail  = (i == seq.size() - 1);
				expected_line_bytes.push_back(entry);
			end
		endfunction

		// Compare one accepted line byte with the oldest expectation
		function void check_line_byte(input logic [sfb_pkg::BYTE_W-1:0] value,
				input logic tail);
			line_byte_t want;
			bytes_checked++;
			if (expected_line_bytes.size() == 0) begin
				$error("unexpected line byte: out_byte=%02h out_last=%0b", value, tail);
				errors++;
				return;
			end
			want = expected_line_bytes.pop_front();
			if (value !== want.value) begin
				$error("out_byte mismatch: expected %02h, actual %02h", want.value, value);
				errors++;
			end
			if (tail !== want.tail) begin
				$error("out_last mismatch: expected %0b, actual %0b", want.tail, tail);
				errors++;
			end
		endfunction

		function int pending();
			return expected_line_bytes.size();
		endfunction
	endclass

endpackage

@@ bench/stuffed_frame_builder_with_checksum_top_tb.sv @@
`timescale 1ns / 100ps
// stuffed_frame_builder_with_checksum_top_tb: directed and random frames under several settings.
// Depends on sfb_pkg, sfb_line_model_pkg and the stuffed_frame_builder_with_checksum_top RTL.
module stuffed_frame_builder_with_checksum_top_tb;

	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASE_ITEMS = 98;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_RUNS
	} stall_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [sfb_pkg::BYTE_W-1:0]       data_byte;
	logic                             last_byte;
	logic                             out_valid;
	logic                             out_stall;
	logic [sfb_pkg::BYTE_W-1:0]       out_byte;
	logic                             out_last;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [sfb_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [sfb_pkg::BYTE_W-1:0]       cfg_data;

	sfb_line_model_pkg::stuffed_stream_tracker line_model;
	int          burst_left = 0;
	int          reg_writes = 0;
	int          spare_writes = 0;
	int          settings_used = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	stuffed_frame_builder_with_checksum_top dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the output on a randomly chosen pattern, picked anew whenever stall_left runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_SPARSE: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_PERIODIC: begin
				out_stall <= (stall_left % 3 == 0);
			end
			default: begin
				out_stall <= ((stall_left / 8) % 2 == 1);
			end
		endcase
	end

	// Note accepted items and check accepted line bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				line_model.predict_frame_bytes(data_byte, last_byte);
			if (out_valid && !out_stall)
				line_model.check_line_byte(out_byte, out_last);
		end
	end

	// Hold the sender in bursts with random gaps in between
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 12);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic [sfb_pkg::BYTE_W-1:0] value, input logic tail);
		data_byte <= value;
		last_byte <= tail;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pace_sender();
	endtask

	// Drop valid and wait until every expected line byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (line_model.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfb_pkg::BYTE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		line_model.set_reg(idx, value);
		reg_writes++;
	endtask

	// Load both registers on an idle block, with stray writes to unused indexes
	task automatic load_settings(input logic [sfb_pkg::BYTE_W-1:0] flag_v,
			input logic [sfb_pkg::BYTE_W-1:0] escape_v);
		wait_drained();
		if ($urandom_range(0, 1) == 1) begin
			write_reg(sfb_line_model_pkg::CFG_SPARE_A, 8'($urandom_range(0, 255)));
			spare_writes++;
		end
		write_reg(sfb_pkg::CFG_FLAG, flag_v);
		if ($urandom_range(0, 1) == 1) begin
			write_reg(sfb_line_model_pkg::CFG_SPARE_B, 8'($urandom_range(0, 255)));
			spare_writes++;
		end
		write_reg(sfb_pkg::CFG_ESCAPE, escape_v);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Favor the bytes that get escaped and the range ends
	function automatic logic [sfb_pkg::BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0, 1: return line_model.flag;
			2: return line_model.escape;
			3: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send frames of random length; mostly short, now and then long
	task automatic random_frames(input int count);
		int sent;
		int flen;
		int k;
		sent = 0;
		while (sent < count) begin
			flen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
			for (k = 0; k < flen && sent < count; k++) begin
				send_item(pick_byte(), k == flen - 1);
				sent++;
			end
		end
	endtask

	initial begin
		logic [sfb_pkg::BYTE_W-1:0] same_v;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		line_model = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one-byte frame with pad, both escapes, escaped last byte
		send_item(8'h00, 1'b1);
		send_item(8'h7E, 1'b0);
		send_item(8'h7D, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h41, 1'b1);
		send_item(8'h7D, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h7E, 1'b1);

		// extreme register values
		load_settings(8'h00, 8'hFF);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h7E, 1'b0);
		send_item(8'h7D, 1'b1);

		// flag equal to escape: a single escape byte
		load_settings(8'h5A, 8'h5A);
		send_item(8'h5A, 1'b0);
		send_item(8'hA5, 1'b1);
		send_item(8'h5A, 1'b1);

		// change registers with a frame open
		send_item(8'h12, 1'b0);
		load_settings(8'hFF, 8'h00);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);

		// random frames under several settings
		load_settings(sfb_pkg::FLAG_RESET, sfb_pkg::ESCAPE_RESET);
		random_frames(RANDOM_PHASE_ITEMS);
		load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		random_frames(RANDOM_PHASE_ITEMS);
		same_v = 8'($urandom_range(0, 255));
		load_settings(same_v, same_v);
		random_frames(RANDOM_PHASE_ITEMS);
		load_settings(8'hFF, 8'h00);
		random_frames(RANDOM_PHASE_ITEMS);

		wait_drained();
		$display("Covered %0d items in %0d closed frames: %0d line bytes, %0d escapes, %0d pads.",
			line_model.inputs_seen, line_model.frames_closed, line_model.bytes_checked,
			line_model.escapes_seen, line_model.pads_seen);
		$display("Applied %0d register settings with %0d writes, %0d of them to unused indexes.",
			settings_used, reg_writes, spare_writes);
		if (line_model.errors == 0 && line_model.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// End a hung run
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
